// ----- src/malu_pkg.sv -----
// Shared types and constants for the Moran allele label update block.
// Used by malu_label_ram and moran_allele_label_update; depends on nothing.
package malu_pkg;

  // Population and field widths
  localparam int POP_SIZE  = 256;
  localparam int SLOT_W    = $clog2(POP_SIZE);
  localparam int INDEX_W   = 8;
  localparam int LABEL_W   = 13;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [LABEL_W-1:0] LABEL_MAX   = {LABEL_W{1'b1}};
  localparam logic [LABEL_W-1:0] FRESH_RESET = LABEL_W'(1);
  localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(POP_SIZE - 1);

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_COPY      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_MUTATE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RELABEL_LIMIT = CFG_IDX_W'(2);

  localparam logic [FRAC_W-1:0]  CUT_COPY_RESET      = FRAC_W'(32768);
  localparam logic [FRAC_W-1:0]  CUT_MUTATE_RESET    = FRAC_W'(33000);
  localparam logic [LABEL_W-1:0] RELABEL_LIMIT_RESET = LABEL_W'(5000);

  typedef enum logic [1:0] {
    KIND_COPY   = 2'd0,
    KIND_MUTATE = 2'd1,
    KIND_SEXUAL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [FRAC_W-1:0]  event_draw;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic [INDEX_W-1:0] third_index;
    logic               parent_pick;
  } item_t;

  typedef struct packed {
    kind_t              event_kind;
    logic [INDEX_W-1:0] target_slot;
    logic [LABEL_W-1:0] written_label;
    logic               relabeled;
    logic [LABEL_W-1:0] label_counter;
  } result_t;

  // Write port of the label memory
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [LABEL_W-1:0] data;
  } ram_wr_t;

endpackage

// ----- src/malu_label_ram.sv -----
// Label memory: one label per individual, one write and one registered read a cycle.
// Depends on malu_pkg. Per-entry valid bits make unwritten entries read as zero.
module malu_label_ram
  import malu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [SLOT_W-1:0]  rd_addr,
  input  ram_wr_t            wr,
  output logic [LABEL_W-1:0] rd_data
);

  logic [LABEL_W-1:0] mem [POP_SIZE];
  logic [POP_SIZE-1:0] vld;
  logic [LABEL_W-1:0] rd_q;
  logic               rd_ok;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      rd_ok <= vld[rd_addr];
    end
  end

  // Never-written entries read as zero through their cleared valid bits
  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// ----- src/moran_allele_label_update.sv -----
// Top level of the Moran allele label update: event decode, sequencer, relabel walk.
// Depends on malu_pkg and malu_label_ram.
//
//  port group           | role       | handshake                 | payload
//  ---------------------+------------+---------------------------+----------------
//  item                 | event in   | item_valid / item_stall   | item_t
//  result               | event out  | result_valid/result_stall | result_t
//  cfg                  | registers  | cfg_write (no wait)       | cfg_index, cfg_data
//
// An ordinary event: the accept cycle issues the memory read, and the cycle after it
// writes the label back and loads the output register if that register is free.
// A mutation that pushes the counter past the limit adds a relabel walk: a minimum
// scan and a subtract pass over the label memory.
// Reset is synchronous; it sets the counter to one, resets the registers and clears
// all entry valid bits, so no clearing pass is needed.
// A stalled result word holds in the output register; the next event is still taken,
// writes back, then holds in the emit step until the register drains, input stalled.
module moran_allele_label_update
  import malu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_SUB,
    ST_SUB_END
  } state_t;

  state_t state;

  // Configuration registers
  logic [FRAC_W-1:0]  cut_copy;
  logic [FRAC_W-1:0]  cut_mutate;
  logic [LABEL_W-1:0] relabel_limit;

  // Event in flight
  kind_t              cur_kind;
  logic [SLOT_W-1:0]  cur_a;
  logic [SLOT_W-1:0]  cur_b;
  logic [SLOT_W-1:0]  cur_c;
  logic [LABEL_W-1:0] fresh_label;
  logic [LABEL_W-1:0] lowest;
  logic [SLOT_W-1:0]  scan_idx;
  logic               cmp_en;
  logic               sub_en;
  logic [SLOT_W-1:0]  sub_addr;
  result_t            res_pend;

  // Memory port
  logic [SLOT_W-1:0]  rd_addr;
  logic [LABEL_W-1:0] rd_data;
  ram_wr_t            wr;

  // Decode and combinational helpers
  kind_t              item_kind;
  logic [SLOT_W-1:0]  item_a;
  logic [SLOT_W-1:0]  item_b;
  logic [SLOT_W-1:0]  item_c;
  logic               item_take;
  logic               slot_free;
  logic [LABEL_W-1:0] fresh_inc;
  logic               do_relabel;
  logic [SLOT_W-1:0]  exec_target;
  logic [LABEL_W-1:0] exec_label;
  result_t            res_now;

  malu_label_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // Take an event only between events; the output register parts the two sides
  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign slot_free  = !result_valid || !result_stall;

  // Indices are reduced modulo the population, a plain truncation at this size
  assign item_a = item.first_index[SLOT_W-1:0];
  assign item_b = item.second_index[SLOT_W-1:0];
  assign item_c = item.third_index[SLOT_W-1:0];

  // Strict unsigned compares against the cumulative cut points, copy first
  always_comb begin
    priority if (item.event_draw < cut_copy) begin
      item_kind = KIND_COPY;
    end else if (item.event_draw < cut_mutate) begin
      item_kind = KIND_MUTATE;
    end else begin
      item_kind = KIND_SEXUAL;
    end
  end

  // Read address: source label on accept, walk index during relabel
  always_comb begin
    rd_addr = scan_idx;
    if (state == ST_IDLE) begin
      if (item_kind == KIND_SEXUAL && item.parent_pick) begin
        rd_addr = item_b;
      end else begin
        rd_addr = item_a;
      end
    end
  end

  // Saturating counter advance and relabel trigger
  assign fresh_inc  = (fresh_label == LABEL_MAX) ? fresh_label : fresh_label + LABEL_W'(1);
  assign do_relabel = (cur_kind == KIND_MUTATE) && (fresh_inc > relabel_limit);

  always_comb begin
    unique case (cur_kind)
      KIND_COPY: begin
        exec_target = cur_b;
        exec_label  = rd_data;
      end
      KIND_MUTATE: begin
        exec_target = cur_a;
        exec_label  = fresh_label;
      end
      default: begin
        exec_target = cur_c;
        exec_label  = rd_data;
      end
    endcase
  end

  always_comb begin
    res_now.event_kind    = cur_kind;
    res_now.target_slot   = INDEX_W'(exec_target);
    res_now.written_label = exec_label;
    res_now.relabeled     = do_relabel;
    res_now.label_counter = (cur_kind == KIND_MUTATE) ? fresh_inc : fresh_label;
  end

  // Write port: event write-back, or subtract pass one entry behind its read
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = exec_target;
    wr.data = exec_label;
    if (state == ST_EXEC) begin
      wr.en = 1'b1;
    end else if (sub_en) begin
      wr.en   = 1'b1;
      wr.addr = sub_addr;
      wr.data = rd_data - lowest;
    end
  end

  // Configuration writes; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cut_copy      <= CUT_COPY_RESET;
      cut_mutate    <= CUT_MUTATE_RESET;
      relabel_limit <= RELABEL_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CUT_COPY:      cut_copy      <= cfg_data;
        CFG_CUT_MUTATE:    cut_mutate    <= cfg_data;
        CFG_RELABEL_LIMIT: relabel_limit <= cfg_data[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the event on accept
  always_ff @(posedge clk) begin
    if (item_take) begin
      cur_kind <= item_kind;
      cur_a    <= item_a;
      cur_b    <= item_b;
      cur_c    <= item_c;
    end
  end

  // Sequencer, counter, relabel walk and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fresh_label  <= FRESH_RESET;
      lowest       <= '0;
      scan_idx     <= '0;
      cmp_en       <= 1'b0;
      sub_en       <= 1'b0;
      sub_addr     <= '0;
      result_valid <= 1'b0;
      result       <= '0;
      res_pend     <= '0;
    end else begin
      // Drain the output register when taken; a load below overrides
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      cmp_en   <= (state == ST_SCAN);
      sub_en   <= (state == ST_SUB);
      sub_addr <= scan_idx;

      // Minimum follows each scanned entry, compared in the cycle after its read
      if (cmp_en && rd_data < lowest) begin
        lowest <= rd_data;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_take) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cur_kind == KIND_MUTATE) begin
            fresh_label <= fresh_inc;
          end
          res_pend <= res_now;
          if (do_relabel) begin
            lowest   <= fresh_inc;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end else if (slot_free) begin
            result       <= res_now;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + SLOT_W'(1);
          if (scan_idx == SLOT_LAST) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          // Last compare lands this cycle; start the subtract pass
          state <= ST_SUB;
        end
        ST_SUB: begin
          scan_idx <= scan_idx + SLOT_W'(1);
          if (scan_idx == SLOT_LAST) begin
            state <= ST_SUB_END;
          end
        end
        ST_SUB_END: begin
          // Final entry is written this cycle; shift the counter and the report
          fresh_label            <= fresh_label - lowest;
          res_pend.written_label <= res_pend.written_label - lowest;
          res_pend.label_counter <= fresh_label - lowest;
          state                  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            result       <= res_pend;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Write-back always follows an accept cycle
  a_exec_after_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> ($past(state) == ST_IDLE))
    else $error("write-back cycle without a preceding accept");

  // The minimum scan must leave the memory untouched
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_SCAN_END) |-> !wr.en)
    else $error("label memory written during minimum scan");

  // A new result word appears only from write-back or the emit step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_EXEC || $past(state) == ST_EMIT))
    else $error("result word loaded outside write-back or emit");

  // Only a mutation can report a relabel
  a_relabel_kind: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.relabeled) |-> (result.event_kind == KIND_MUTATE))
    else $error("relabel flagged on a non-mutation event");

  // Never write a label above the counter after a relabel
  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) && result.relabeled |->
      (result.written_label <= result.label_counter))
    else $error("relabelled label exceeds the counter");

endmodule

// ----- test/tb_moran_allele_label_update.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for moran_allele_label_update: directed table and randomised
// phases, checked word by word against an in-bench label table model.
// Depends on malu_pkg and the block's RTL only.
module tb_moran_allele_label_update;
  import malu_pkg::*;

  // No cycle without a handshake may last this long: one relabel walk plus the long
  // receiver hold-off stays far below it
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 2 * POP_SIZE + 8;
  localparam int PRINT_LIMIT    = 40;

  // Register index past the last one; a write to it must leave every register alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  typedef enum bit {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    item_t                  word;
    bit                     known;
    result_t                want;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_val;
  } row_t;

  typedef struct {
    logic [FRAC_W-1:0]  copy_cut;
    logic [FRAC_W-1:0]  mutate_cut;
    logic [LABEL_W-1:0] limit;
    int unsigned        words;
    bit                 random_cuts;
    bit                 idle;
    bit                 long_hold;
  } phase_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  // Mirror of the block: label table, fresh label counter and registers
  logic [LABEL_W-1:0] label_mirror [POP_SIZE];
  logic [LABEL_W-1:0] fresh_mirror;
  logic [FRAC_W-1:0]  copy_cut;
  logic [FRAC_W-1:0]  mutate_cut;
  logic [LABEL_W-1:0] shift_limit;

  // Results still owed by the block, oldest first
  result_t     pending_results [$];

  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;
  int unsigned stall_left    = 0;
  bit          bubbles       = 1'b1;

  row_t   directed_rows [23];
  phase_t phases [6];

  moran_allele_label_update i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------------------
  // Label table model: apply one event to the mirror and return the word it must produce
  // ------------------------------------------------------------------------------------
  function automatic result_t apply_event(input item_t w);
    logic [SLOT_W-1:0]  a;
    logic [SLOT_W-1:0]  b;
    logic [SLOT_W-1:0]  c;
    logic [SLOT_W-1:0]  tgt;
    logic [LABEL_W-1:0] lowest;
    result_t            r;
    a = SLOT_W'(w.first_index % POP_SIZE);
    b = SLOT_W'(w.second_index % POP_SIZE);
    c = SLOT_W'(w.third_index % POP_SIZE);
    r = '0;
    if (w.event_draw < copy_cut) begin
      r.event_kind = KIND_COPY;
      tgt = b;
      label_mirror[b] = label_mirror[a];
    end else if (w.event_draw < mutate_cut) begin
      r.event_kind = KIND_MUTATE;
      tgt = a;
      label_mirror[a] = fresh_mirror;
      // counter sticks at its top value
      if (fresh_mirror != LABEL_MAX) begin
        fresh_mirror = fresh_mirror + 1'b1;
      end
      // shift every label down by the smallest one, the counter included
      if (fresh_mirror > shift_limit) begin
        lowest = fresh_mirror;
        foreach (label_mirror[k]) begin
          if (label_mirror[k] < lowest) begin
            lowest = label_mirror[k];
          end
        end
        foreach (label_mirror[k]) begin
          label_mirror[k] = label_mirror[k] - lowest;
        end
        fresh_mirror = fresh_mirror - lowest;
        r.relabeled = 1'b1;
      end
    end else begin
      r.event_kind = KIND_SEXUAL;
      tgt = c;
      label_mirror[c] = w.parent_pick ? label_mirror[b] : label_mirror[a];
    end
    r.target_slot   = INDEX_W'(tgt);
    r.written_label = label_mirror[tgt];
    r.label_counter = fresh_mirror;
    return r;
  endfunction

  // ------------------------------------------------------------------------------------
  // Directed table rows
  // ------------------------------------------------------------------------------------
  function automatic row_t event_row(input logic [FRAC_W-1:0] draw,
                                     input logic [INDEX_W-1:0] a, b, c,
                                     input logic pick);
    row_t r;
    r = '{ROW_EVENT, '{draw, a, b, c, pick}, 1'b0, '0, CFG_CUT_COPY, '0};
    return r;
  endfunction

  function automatic row_t known_row(input logic [FRAC_W-1:0] draw,
                                     input logic [INDEX_W-1:0] a, b, c,
                                     input logic pick, input kind_t kind,
                                     input logic [INDEX_W-1:0] slot,
                                     input logic [LABEL_W-1:0] label,
                                     input logic rel,
                                     input logic [LABEL_W-1:0] counter);
    row_t r;
    r = event_row(draw, a, b, c, pick);
    r.known = 1'b1;
    r.want  = '{kind, slot, label, rel, counter};
    return r;
  endfunction

  function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
    row_t r;
    r = '{ROW_WRITE, '0, 1'b0, '0, idx, val};
    return r;
  endfunction

  // ------------------------------------------------------------------------------------
  // Random words
  // ------------------------------------------------------------------------------------
  function automatic item_t random_word();
    item_t w;
    w.event_draw   = FRAC_W'($urandom_range(0, 65535));
    w.first_index  = INDEX_W'($urandom_range(0, 255));
    w.second_index = INDEX_W'($urandom_range(0, 255));
    w.third_index  = INDEX_W'($urandom_range(0, 255));
    w.parent_pick  = 1'($urandom_range(0, 1));
    // now and then land on or just below a cut point, where the strict compares matter
    case ($urandom_range(0, 7))
      0: w.event_draw = copy_cut;
      1: w.event_draw = mutate_cut;
      2: w.event_draw = mutate_cut - 1'b1;
      default: ;
    endcase
    return w;
  endfunction

  // ------------------------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------------------------
  // Offer one word, hold it until taken, then log what the block owes for it
  task automatic send_word(input item_t w, input bit known, input result_t want);
    int unsigned gap;
    result_t     predicted;
    if (bubbles && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = apply_event(w);
    pending_results.push_back(known ? want : predicted);
  endtask

  // Drop valid and wait for the block to hand back every owed word
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One register write; the mirror follows at the same edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_CUT_COPY:      copy_cut    = val;
      CFG_CUT_MUTATE:    mutate_cut  = val;
      CFG_RELABEL_LIMIT: shift_limit = LABEL_W'(val);
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] result word %0d: %s", $time, words_checked, what);
    end
  endtask

  // ------------------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off whenever one is asked for
  // ------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (holds_asked != holds_served) begin
      result_stall <= 1'b1;
      stall_left   <= LONG_HOLD - 1;
      holds_served <= holds_served + 1;
    end else if (bubbles && $urandom_range(0, 7) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 9);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------------------------------
  // Checker: every word taken from the block against the oldest expectation
  // ------------------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (result.event_kind !== want.event_kind) begin
          report_mismatch($sformatf("event_kind %0d, expected %0d",
                                    result.event_kind, want.event_kind));
        end
        if (result.target_slot !== want.target_slot) begin
          report_mismatch($sformatf("target_slot %0d, expected %0d",
                                    result.target_slot, want.target_slot));
        end
        if (result.written_label !== want.written_label) begin
          report_mismatch($sformatf("written_label %0d, expected %0d",
                                    result.written_label, want.written_label));
        end
        if (result.relabeled !== want.relabeled) begin
          report_mismatch($sformatf("relabeled %0b, expected %0b",
                                    result.relabeled, want.relabeled));
        end
        if (result.label_counter !== want.label_counter) begin
          report_mismatch($sformatf("label_counter %0d, expected %0d",
                                    result.label_counter, want.label_counter));
        end
      end
      words_checked++;
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------------------
  initial begin : stimulus
    logic [FRAC_W-1:0]  pc;
    logic [FRAC_W-1:0]  pm;
    logic [LABEL_W-1:0] pl;

    // Table state after reset: all labels zero, counter at one, registers at reset values
    foreach (label_mirror[k]) begin
      label_mirror[k] = '0;
    end
    fresh_mirror = FRESH_RESET;
    copy_cut     = CUT_COPY_RESET;
    mutate_cut   = CUT_MUTATE_RESET;
    shift_limit  = RELABEL_LIMIT_RESET;

    // Directed part. Typed expectations are the ones that follow straight from the
    // reset state; the rest come from the mirror.
    directed_rows = '{
      // copy from slot 0 into the last slot, still all zero
      known_row(16'd0, 8'd0, 8'd255, 8'd0, 1'b0, KIND_COPY, 8'd255, 13'd0, 1'b0, 13'd1),
      // lowest mutation draw, then the highest one below the mutation cut
      known_row(16'd32768, 8'd0, 8'd0, 8'd0, 1'b0,
                KIND_MUTATE, 8'd0, 13'd1, 1'b0, 13'd2),
      known_row(16'd32999, 8'd255, 8'd0, 8'd0, 1'b0,
                KIND_MUTATE, 8'd255, 13'd2, 1'b0, 13'd3),
      // sexual at the mutation cut and at the top draw, each parent once
      known_row(16'd33000, 8'd0, 8'd255, 8'd7, 1'b0,
                KIND_SEXUAL, 8'd7, 13'd1, 1'b0, 13'd3),
      known_row(16'd65535, 8'd0, 8'd255, 8'd8, 1'b1,
                KIND_SEXUAL, 8'd8, 13'd2, 1'b0, 13'd3),
      // copy onto itself just below the copy cut
      known_row(16'd32767, 8'd255, 8'd255, 8'd0, 1'b0,
                KIND_COPY, 8'd255, 13'd2, 1'b0, 13'd3),
      event_row(16'd65535, 8'd7, 8'd7, 8'd7, 1'b1),
      event_row(16'd1234, 8'd8, 8'd9, 8'd0, 1'b0),
      // write past the last register: the next mutation must see the old limit
      write_row(CFG_UNUSED, 16'hFFFF),
      known_row(16'd32800, 8'd10, 8'd0, 8'd0, 1'b0,
                KIND_MUTATE, 8'd10, 13'd3, 1'b0, 13'd4),
      // tight limits: each mutation shifts the table down
      write_row(CFG_RELABEL_LIMIT, 16'd4),
      event_row(16'd32900, 8'd11, 8'd0, 8'd0, 1'b0),
      write_row(CFG_RELABEL_LIMIT, 16'd1),
      event_row(16'd32768, 8'd12, 8'd0, 8'd0, 1'b0),
      // mutation cut at or below the copy cut: no draw may mutate
      write_row(CFG_CUT_COPY, 16'hFFFF),
      write_row(CFG_CUT_MUTATE, 16'd0),
      event_row(16'd65534, 8'd1, 8'd2, 8'd0, 1'b0),
      event_row(16'd65535, 8'd2, 8'd3, 8'd4, 1'b0),
      // copy cut at zero: even a zero draw is not a copy
      write_row(CFG_CUT_COPY, 16'd0),
      event_row(16'd0, 8'd200, 8'd201, 8'd255, 1'b1),
      write_row(CFG_CUT_MUTATE, 16'hFFFF),
      event_row(16'd65534, 8'd254, 8'd0, 8'd0, 1'b0),
      write_row(CFG_RELABEL_LIMIT, 16'd8000)
    };

    phases = '{
      '{CUT_COPY_RESET, CUT_MUTATE_RESET, RELABEL_LIMIT_RESET, 300, 1'b0, 1'b1, 1'b1},
      '{16'd0,      16'd0,      13'd1,    250, 1'b0, 1'b1, 1'b0},
      '{16'hFFFF,   16'hFFFF,   13'd8000, 250, 1'b0, 1'b1, 1'b0},
      '{16'd20000,  16'd45000,  13'd300,  350, 1'b0, 1'b1, 1'b1},
      '{16'd0,      16'd0,      13'd1,    300, 1'b1, 1'b1, 1'b0},
      '{16'd16384,  16'd49152,  13'd2000, 300, 1'b0, 1'b0, 1'b0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        drain();
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
      end else begin
        send_word(directed_rows[k].word, directed_rows[k].known, directed_rows[k].want);
      end
    end

    // Random phases, each under its own register settings
    foreach (phases[p]) begin
      drain();
      pc = phases[p].copy_cut;
      pm = phases[p].mutate_cut;
      pl = phases[p].limit;
      if (phases[p].random_cuts) begin
        pc = FRAC_W'($urandom_range(0, 65535));
        pm = FRAC_W'($urandom_range(0, 65535));
        pl = LABEL_W'($urandom_range(1, 8000));
      end
      write_reg(CFG_CUT_COPY, pc);
      write_reg(CFG_CUT_MUTATE, pm);
      write_reg(CFG_RELABEL_LIMIT, CFG_W'(pl));
      bubbles = phases[p].idle;
      // ask the receiver to sit on its stall while words keep coming
      if (phases[p].long_hold) begin
        holds_asked <= holds_asked + 1;
      end
      repeat (phases[p].words) send_word(random_word(), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
